// File: sv/assert_macros.svh
// Assertion macros used by the verification checker of the key press classifier.
// This header has no dependencies. The checker includes it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define KPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("key press classifier assertion failed");

// Checked on every rising edge, during reset as well.
`define KPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("key press classifier assertion failed");

`endif

// File: sv/kpc_pkg.sv
// Shared types, field layouts and constants for the key press classifier.
// This package has no dependencies. The update logic, the top level and the checker use it.
`default_nettype none

package kpc_pkg;

    localparam int KEY_COUNT_DEF = 2;
    localparam int KEY_COUNT_MAX = 32;

    localparam int TIME_W   = 32;
    localparam int TALLY_W  = 16;
    localparam int CLASS_W  = 3;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 2;

    // Input tdata: key_index [0], pin_level [1], now_ms [33:2], zero padding.
    localparam int S_TDATA_W = 40;
    localparam int S_KEY_LSB = 0;
    localparam int S_PIN_LSB = 1;
    localparam int S_NOW_LSB = 2;

    // Output tdata: key_number [0], press_class [3:1], repeat_count [19:4],
    // held [20], zero padding.
    localparam int M_TDATA_W  = 24;
    localparam int M_KEY_LSB  = 0;
    localparam int M_CLS_LSB  = 1;
    localparam int M_CNT_LSB  = 4;
    localparam int M_HELD_LSB = 20;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE   = 3'd0,
        CLS_SHORT  = 3'd1,
        CLS_LONG   = 3'd2,
        CLS_KEEP   = 3'd3,
        CLS_REPEAT = 3'd4
    } press_class_t;

    localparam logic [CFG_AW-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_KEEP_LONG  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_REPEAT     = 2'd2;
    localparam logic [CFG_AW-1:0] REG_LOCK_SCANS = 2'd3;

    localparam logic [TIME_W-1:0]  LONG_PRESS_RST = 32'd1000;
    localparam logic [TIME_W-1:0]  KEEP_LONG_RST  = 32'd5000;
    localparam logic [TIME_W-1:0]  REPEAT_RST     = 32'd200;
    localparam logic [TALLY_W-1:0] LOCK_SCANS_RST = 16'd300;

    typedef struct packed {
        logic [TIME_W-1:0]  long_press_ms;
        logic [TIME_W-1:0]  keep_long_ms;
        logic [TIME_W-1:0]  repeat_ms;
        logic [TALLY_W-1:0] lock_scans;
    } kpc_cfg_t;

    typedef struct packed {
        logic               last_pressed;
        logic [TIME_W-1:0]  press_start;
        logic [TIME_W-1:0]  repeat_start;
        logic [TALLY_W-1:0] repeat_tally;
        press_class_t       class_code;
        logic [TALLY_W-1:0] lock_tally;
    } key_state_t;

endpackage

`default_nettype wire

// File: sv/kpc_update.sv
// Next-state logic of one key for one scan: press edge, repeats, release class and lock count.
// Depends on kpc_pkg for the key state and configuration structs.
`default_nettype none

module kpc_update (
    input  kpc_pkg::kpc_cfg_t       cfg,
    input  kpc_pkg::key_state_t     cur,
    input  logic                    pressed,
    input  logic [kpc_pkg::TIME_W-1:0] now_ms,
    output kpc_pkg::key_state_t     nxt
);
    import kpc_pkg::*;

    logic [TIME_W-1:0]  hold_ms;
    logic [TIME_W-1:0]  since_repeat_ms;
    logic [TALLY_W-1:0] lock_inc;
    key_state_t         mid;

    assign hold_ms         = now_ms - cur.press_start;
    assign since_repeat_ms = now_ms - cur.repeat_start;

    always_comb begin
        mid = cur;
        if (pressed) begin
            if (!cur.last_pressed) begin
                mid.press_start  = now_ms;
                mid.repeat_start = now_ms;
                mid.repeat_tally = '0;
            end else if (hold_ms > cfg.keep_long_ms) begin
                mid = cur;
            end else if (since_repeat_ms > cfg.repeat_ms) begin
                mid.repeat_start = now_ms;
                mid.class_code   = CLS_REPEAT;
                mid.repeat_tally = cur.repeat_tally + TALLY_W'(1);
            end
        end else if (cur.last_pressed) begin
            if (hold_ms > cfg.keep_long_ms) begin
                mid.class_code = CLS_KEEP;
            end else if (hold_ms > cfg.long_press_ms) begin
                mid.class_code = CLS_LONG;
            end else begin
                mid.class_code = CLS_SHORT;
            end
            mid.lock_tally = '0;
        end
        mid.last_pressed = pressed;
    end

    assign lock_inc = mid.lock_tally + TALLY_W'(1);

    always_comb begin
        nxt = mid;
        if (mid.class_code == CLS_SHORT || mid.class_code == CLS_LONG) begin
            if (lock_inc >= cfg.lock_scans) begin
                nxt.class_code = CLS_NONE;
                nxt.lock_tally = '0;
            end else begin
                nxt.lock_tally = lock_inc;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/key_press_classifier_unit.sv
// An accepted item is first held in the input register, then its result in the result
// register. The input register and the result register each hold one item, and the
// per-key state is updated in the edge that loads the result, so back-to-back scans of
// one key see each other's effect. One item per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties both registers, clears all key state and
// loads the configuration defaults.
`default_nettype none

module key_press_classifier_unit #(
    parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // key_index [0], pin_level [1], now_ms [33:2], zero padding
    input  logic [kpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_number [0], press_class [3:1], repeat_count [19:4], held [20], zero padding
    output logic [kpc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wen,
    input  logic [kpc_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [kpc_pkg::CFG_W-1:0]     cfg_wdata
);
    import kpc_pkg::*;

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KW_W  = $clog2(KEY_COUNT_MAX) + 1;

    kpc_cfg_t   cfg_reg;
    key_state_t st_reg [KEY_COUNT];

    logic              in_v_reg;
    logic              in_key_reg;
    logic              in_pin_reg;
    logic [TIME_W-1:0] in_now_reg;

    logic                 out_v_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic             advance;
    logic             pressed;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    key_state_t       cur_st;
    key_state_t       upd_st;
    press_class_t     res_class;
    logic [TALLY_W-1:0] res_count;
    logic [M_TDATA_W-1:0] out_data_next;

    assign advance  = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || advance;

    assign pressed  = !in_pin_reg;
    assign in_range = KW_W'(in_key_reg) < KW_W'(KEY_COUNT);
    assign idx      = IDX_W'(in_key_reg);
    assign cur_st   = st_reg[idx];

    kpc_update u_update (
        .cfg     (cfg_reg),
        .cur     (cur_st),
        .pressed (pressed),
        .now_ms  (in_now_reg),
        .nxt     (upd_st)
    );

    assign res_class = in_range ? upd_st.class_code : CLS_NONE;
    assign res_count = in_range ? upd_st.repeat_tally : '0;

    always_comb begin
        out_data_next                         = '0;
        out_data_next[M_KEY_LSB]              = in_key_reg;
        out_data_next[M_CLS_LSB +: CLASS_W]   = res_class;
        out_data_next[M_CNT_LSB +: TALLY_W]   = res_count;
        out_data_next[M_HELD_LSB]             = pressed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.keep_long_ms  <= KEEP_LONG_RST;
            cfg_reg.repeat_ms     <= REPEAT_RST;
            cfg_reg.lock_scans    <= LOCK_SCANS_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_wdata;
                REG_KEEP_LONG:  cfg_reg.keep_long_ms  <= cfg_wdata;
                REG_REPEAT:     cfg_reg.repeat_ms     <= cfg_wdata;
                REG_LOCK_SCANS: cfg_reg.lock_scans    <= cfg_wdata[TALLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg <= s_tdata[S_KEY_LSB];
            in_pin_reg <= s_tdata[S_PIN_LSB];
            in_now_reg <= s_tdata[S_NOW_LSB +: TIME_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                st_reg[k] <= '0;
            end
        end else if (advance && in_range) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (idx == IDX_W'(k)) begin
                    st_reg[k] <= upd_st;
                end
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: sv/kpc_checker.sv
// Port-level checker for the key press classifier, bound to the top level.
// Depends on kpc_pkg for the field layout and on assert_macros.svh for the assertion macros.
`default_nettype none

`include "assert_macros.svh"

module kpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [kpc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [kpc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import kpc_pkg::*;

    logic [CLASS_W-1:0] out_class;
    logic               out_held;
    logic               in_item;

    assign out_class = m_tdata[M_CLS_LSB +: CLASS_W];
    assign out_held  = m_tdata[M_HELD_LSB];
    assign in_item   = s_tvalid && s_tready && (s_tdata[S_KEY_LSB] || !s_tdata[S_KEY_LSB]);

    `KPC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `KPC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `KPC_ASSERT(a_class_range, aclk, aresetn, m_tvalid |-> out_class <= CLASS_W'(CLS_REPEAT))
    `KPC_ASSERT(a_repeat_held, aclk, aresetn, m_tvalid && out_class == CLASS_W'(CLS_REPEAT) |-> out_held)
    `KPC_ASSERT(a_item_flows, aclk, aresetn, in_item && m_tready |=> ##1 m_tvalid)

endmodule

bind key_press_classifier_unit kpc_checker u_kpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
